@@ rtl/overlap_crossfade_stitcher_assert.svh @@
// ----------------------------------------------------------------------------
// Overlap crossfade stitcher assertion macros
// Concurrent checks, clocked and held off during reset. Define ASSERT_OFF to
// compile them away.
// ----------------------------------------------------------------------------
`ifndef OVERLAP_CROSSFADE_STITCHER_ASSERT_SVH
`define OVERLAP_CROSSFADE_STITCHER_ASSERT_SVH
`ifndef ASSERT_OFF
`define OCS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define OCS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`else
`define OCS_ASSERT(label, clk, rst, prop, msg)
`define OCS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/ocs_pkg.sv @@
// ----------------------------------------------------------------------------
// ocs_pkg
// Widths, payload types and the PCM conversion shared by the stitcher.
// ----------------------------------------------------------------------------
package ocs_pkg;

   localparam int SAMPLE_W = 20;
   localparam int PCM_W    = 16;
   localparam int OVL_W    = 6;
   localparam int MAX_OVL  = 63;
   localparam int POS_W    = 16;
   localparam int PROD_W   = SAMPLE_W + OVL_W;
   localparam int NUM_W    = PROD_W + 1;

   localparam logic [OVL_W-1:0] OVL_RESET = OVL_W'(32);

   localparam logic signed [SAMPLE_W-1:0] CLIP_HI = SAMPLE_W'(32768);
   localparam logic signed [SAMPLE_W-1:0] CLIP_LO = SAMPLE_W'(-32768);
   localparam logic signed [SAMPLE_W-1:0] S_ONE   = SAMPLE_W'(1);
   localparam logic signed [SAMPLE_W-1:0] S_ZERO  = SAMPLE_W'(0);

   typedef struct packed {
      logic                       cmd;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       chunk_end;
      logic                       final_window;
   } req_type;

   typedef struct packed {
      logic signed [PCM_W-1:0] pcm;
      logic                    run_last;
   } rsp_type;

   typedef struct packed {
      logic                       push;
      logic                       finish;
      logic signed [SAMPLE_W-1:0] value;
   } emit_ctl_type;

   // Clip to +/-1.0 and scale by 32767/32768, truncating toward zero
   function automatic logic signed [PCM_W-1:0] to_pcm(logic signed [SAMPLE_W-1:0] v);
      logic signed [SAMPLE_W-1:0] c;
      logic signed [SAMPLE_W-1:0] p;
      if (v > CLIP_HI) begin
         c = CLIP_HI;
      end else if (v < CLIP_LO) begin
         c = CLIP_LO;
      end else begin
         c = v;
      end
      if (c > S_ZERO) begin
         p = c - S_ONE;
      end else if (c < S_ZERO) begin
         p = c + S_ONE;
      end else begin
         p = S_ZERO;
      end
      return p[PCM_W-1:0];
   endfunction

endpackage

@@ rtl/overlap_crossfade_stitcher.sv @@
// ----------------------------------------------------------------------------
// overlap_crossfade_stitcher
// Joins consecutive audio chunks with a linear crossfade over ovl_len samples
// and converts the result to 16-bit PCM.
//
// req_* carries one transaction per audio sample or drain command; rsp_* gives
// zero or more PCM results per transaction, run_last set on the final one.
// csr_we/csr_wdata write ovl_len; write it only while the block is idle.
// One transaction is processed at a time; req_stall is high while it runs.
// Every ring or tail entry that is flushed, drained or copied is handled as a
// RAM read, then a use. A crossfaded sample waits on the one-bit-per-cycle
// divider. The last result of a transaction is released when the transaction
// ends. A stalled receiver holds the output register; the block waits on it
// and loses nothing. Synchronous reset clears the fill state, drops any held
// tail and sets ovl_len to 32; RAM contents are left as they are.
// ----------------------------------------------------------------------------
`include "overlap_crossfade_stitcher_assert.svh"

module overlap_crossfade_stitcher #(
   parameter int MAX_OVL = ocs_pkg::MAX_OVL
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  ocs_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output ocs_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [ocs_pkg::OVL_W-1:0]     csr_wdata
);

   localparam int OVL_W  = ocs_pkg::OVL_W;
   localparam int POS_W  = ocs_pkg::POS_W;
   localparam int SW     = ocs_pkg::SAMPLE_W;
   localparam int PROD_W = ocs_pkg::PROD_W;
   localparam int NUM_W  = ocs_pkg::NUM_W;
   localparam int AW     = (MAX_OVL > 1) ? $clog2(MAX_OVL) : 1;

   typedef enum logic [4:0] {
      S_IDLE, S_DECIDE, S_FLUSH_RD, S_FLUSH_EM, S_TAIL_RD, S_MUL, S_SUM, S_DIV,
      S_EMIT_V, S_POP_CHK, S_POP_RD, S_POP_EM, S_PUSH, S_END, S_COPY_RD,
      S_COPY_WR, S_DRAIN_RD, S_DRAIN_EM, S_FINISH
   } state_type;

   function automatic logic [AW-1:0] wrap_add(logic [OVL_W-1:0] a, logic [OVL_W-1:0] b);
      logic [OVL_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (OVL_W+1)'(MAX_OVL)) begin
         s = s - (OVL_W+1)'(MAX_OVL);
      end
      return s[AW-1:0];
   endfunction

   state_type                state_ff, state_in;
   logic [OVL_W-1:0]         ovl_len_ff, ovl_len_in;
   logic                     tail_valid_ff, tail_valid_in;
   logic [OVL_W-1:0]         ring_count_ff, ring_count_in;
   logic [AW-1:0]            ring_head_ff, ring_head_in;
   logic [POS_W-1:0]         chunk_pos_ff, chunk_pos_in;
   ocs_pkg::req_type         item_ff, item_in;
   logic [OVL_W-1:0]         len_ff, len_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [OVL_W-1:0]         k_ff, k_in;
   logic                     blend_ff, blend_in;
   logic                     flush_end_ff, flush_end_in;
   logic signed [PROD_W-1:0] prod_a_ff, prod_a_in;
   logic signed [PROD_W-1:0] prod_b_ff, prod_b_in;

   logic [OVL_W-1:0]         eff_len;
   logic                     blend_now;
   logic [OVL_W-1:0]         len_minus_pos;

   logic                     ring_wr_en, ring_rd_en;
   logic [AW-1:0]            ring_wr_addr, ring_rd_addr;
   logic [SW-1:0]            ring_wr_data, ring_rd_data;
   logic                     tail_wr_en, tail_rd_en;
   logic [AW-1:0]            tail_wr_addr, tail_rd_addr;
   logic [SW-1:0]            tail_wr_data, tail_rd_data;

   logic                     div_start, div_busy;
   logic signed [NUM_W-1:0]  div_num;
   logic signed [SW-1:0]     div_quo;

   ocs_pkg::emit_ctl_type    emit_ctl;
   logic                     emit_ready;

   always_comb begin
      if (ovl_len_ff == '0) begin
         eff_len = OVL_W'(1);
      end else if (ovl_len_ff > OVL_W'(MAX_OVL)) begin
         eff_len = OVL_W'(MAX_OVL);
      end else begin
         eff_len = ovl_len_ff;
      end
   end

   assign blend_now     = tail_valid_ff && (pos_ff < POS_W'(len_ff));
   assign len_minus_pos = len_ff - pos_ff[OVL_W-1:0];
   assign req_stall     = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      ovl_len_in    = ovl_len_ff;
      tail_valid_in = tail_valid_ff;
      ring_count_in = ring_count_ff;
      ring_head_in  = ring_head_ff;
      chunk_pos_in  = chunk_pos_ff;
      item_in       = item_ff;
      len_in        = len_ff;
      pos_in        = pos_ff;
      k_in          = k_ff;
      blend_in      = blend_ff;
      flush_end_in  = flush_end_ff;
      prod_a_in     = prod_a_ff;
      prod_b_in     = prod_b_ff;

      ring_wr_en    = 1'b0;
      ring_wr_addr  = wrap_add(OVL_W'(ring_head_ff), ring_count_ff);
      ring_wr_data  = item_ff.sample;
      ring_rd_en    = 1'b0;
      ring_rd_addr  = ring_head_ff;
      tail_wr_en    = 1'b0;
      tail_wr_addr  = k_ff[AW-1:0];
      tail_wr_data  = ring_rd_data;
      tail_rd_en    = 1'b0;
      tail_rd_addr  = k_ff[AW-1:0];
      div_start     = 1'b0;
      div_num       = NUM_W'(prod_a_ff) + NUM_W'(prod_b_ff);
      emit_ctl      = '0;

      if (csr_we) begin
         ovl_len_in = csr_wdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               len_in   = eff_len;
               pos_in   = chunk_pos_ff;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            k_in = '0;
            if (item_ff.cmd) begin
               state_in = (pos_ff == '0 && tail_valid_ff) ? S_DRAIN_RD : S_FINISH;
            end else if (blend_now || item_ff.final_window) begin
               blend_in     = blend_now;
               flush_end_in = 1'b0;
               if (ring_count_ff != '0) begin
                  state_in = S_FLUSH_RD;
               end else begin
                  ring_head_in = '0;
                  state_in     = blend_now ? S_TAIL_RD : S_EMIT_V;
               end
            end else begin
               state_in = S_POP_CHK;
            end
         end
         S_FLUSH_RD: begin
            ring_rd_en = 1'b1;
            state_in   = S_FLUSH_EM;
         end
         S_FLUSH_EM: begin
            if (emit_ready) begin
               emit_ctl.push  = 1'b1;
               emit_ctl.value = $signed(ring_rd_data);
               if (ring_count_ff == OVL_W'(1)) begin
                  ring_count_in = '0;
                  ring_head_in  = '0;
                  if (flush_end_ff) begin
                     state_in = S_FINISH;
                  end else begin
                     state_in = blend_ff ? S_TAIL_RD : S_EMIT_V;
                  end
               end else begin
                  ring_count_in = ring_count_ff - OVL_W'(1);
                  ring_head_in  = wrap_add(OVL_W'(ring_head_ff), OVL_W'(1));
                  state_in      = S_FLUSH_RD;
               end
            end
         end
         S_TAIL_RD: begin
            tail_rd_en   = 1'b1;
            tail_rd_addr = pos_ff[AW-1:0];
            state_in     = S_MUL;
         end
         S_MUL: begin
            prod_a_in = PROD_W'($signed(tail_rd_data))
                      * PROD_W'($signed({1'b0, len_minus_pos}));
            prod_b_in = PROD_W'(item_ff.sample)
                      * PROD_W'($signed({1'b0, pos_ff[OVL_W-1:0]}));
            state_in  = S_SUM;
         end
         S_SUM: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (!div_busy && emit_ready) begin
               emit_ctl.push  = 1'b1;
               emit_ctl.value = div_quo;
               state_in       = S_END;
            end
         end
         S_EMIT_V: begin
            if (emit_ready) begin
               emit_ctl.push  = 1'b1;
               emit_ctl.value = item_ff.sample;
               state_in       = S_END;
            end
         end
         S_POP_CHK: begin
            state_in = (ring_count_ff >= len_ff) ? S_POP_RD : S_PUSH;
         end
         S_POP_RD: begin
            ring_rd_en = 1'b1;
            state_in   = S_POP_EM;
         end
         S_POP_EM: begin
            if (emit_ready) begin
               emit_ctl.push  = 1'b1;
               emit_ctl.value = $signed(ring_rd_data);
               ring_count_in  = ring_count_ff - OVL_W'(1);
               ring_head_in   = wrap_add(OVL_W'(ring_head_ff), OVL_W'(1));
               state_in       = S_POP_CHK;
            end
         end
         S_PUSH: begin
            ring_wr_en    = 1'b1;
            ring_count_in = ring_count_ff + OVL_W'(1);
            state_in      = S_END;
         end
         S_END: begin
            if (item_ff.chunk_end) begin
               chunk_pos_in = '0;
               if (!item_ff.final_window && ring_count_ff == len_ff &&
                   (tail_valid_ff || pos_ff >= POS_W'(len_ff))) begin
                  k_in     = '0;
                  state_in = S_COPY_RD;
               end else begin
                  tail_valid_in = 1'b0;
                  if (ring_count_ff != '0) begin
                     flush_end_in = 1'b1;
                     state_in     = S_FLUSH_RD;
                  end else begin
                     ring_head_in = '0;
                     state_in     = S_FINISH;
                  end
               end
            end else begin
               if (pos_ff != '1) begin
                  chunk_pos_in = pos_ff + POS_W'(1);
               end
               state_in = S_FINISH;
            end
         end
         S_COPY_RD: begin
            ring_rd_en   = 1'b1;
            ring_rd_addr = wrap_add(OVL_W'(ring_head_ff), k_ff);
            state_in     = S_COPY_WR;
         end
         S_COPY_WR: begin
            tail_wr_en = 1'b1;
            if (k_ff == len_ff - OVL_W'(1)) begin
               ring_count_in = '0;
               ring_head_in  = '0;
               tail_valid_in = 1'b1;
               state_in      = S_FINISH;
            end else begin
               k_in     = k_ff + OVL_W'(1);
               state_in = S_COPY_RD;
            end
         end
         S_DRAIN_RD: begin
            tail_rd_en = 1'b1;
            state_in   = S_DRAIN_EM;
         end
         S_DRAIN_EM: begin
            if (emit_ready) begin
               emit_ctl.push  = 1'b1;
               emit_ctl.value = $signed(tail_rd_data);
               if (k_ff == len_ff - OVL_W'(1)) begin
                  tail_valid_in = 1'b0;
                  state_in      = S_FINISH;
               end else begin
                  k_in     = k_ff + OVL_W'(1);
                  state_in = S_DRAIN_RD;
               end
            end
         end
         S_FINISH: begin
            // release the held result with its last-of-transaction mark
            if (emit_ready) begin
               emit_ctl.finish = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ovl_len_ff    <= ocs_pkg::OVL_RESET;
         tail_valid_ff <= 1'b0;
         ring_count_ff <= '0;
         ring_head_ff  <= '0;
         chunk_pos_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         ovl_len_ff    <= ovl_len_in;
         tail_valid_ff <= tail_valid_in;
         ring_count_ff <= ring_count_in;
         ring_head_ff  <= ring_head_in;
         chunk_pos_ff  <= chunk_pos_in;
      end
      item_ff      <= item_in;
      len_ff       <= len_in;
      pos_ff       <= pos_in;
      k_ff         <= k_in;
      blend_ff     <= blend_in;
      flush_end_ff <= flush_end_in;
      prod_a_ff    <= prod_a_in;
      prod_b_ff    <= prod_b_in;
   end

   // Ring and tail accesses are sequenced by the state machine, so no entry
   // is read and written in the same cycle.
   ocs_ram #(
      .WIDTH  (SW),
      .DEPTH  (MAX_OVL),
      .ADDR_W (AW)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_wr_addr),
      .wr_data (ring_wr_data),
      .rd_en   (ring_rd_en),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   ocs_ram #(
      .WIDTH  (SW),
      .DEPTH  (MAX_OVL),
      .ADDR_W (AW)
   ) u_tail_ram (
      .clock   (clock),
      .wr_en   (tail_wr_en),
      .wr_addr (tail_wr_addr),
      .wr_data (tail_wr_data),
      .rd_en   (tail_rd_en),
      .rd_addr (tail_rd_addr),
      .rd_data (tail_rd_data)
   );

   ocs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (len_ff),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   ocs_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .ctl       (emit_ctl),
      .ready     (emit_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `OCS_ASSERT(a_ring_bound, clock, reset, ring_count_ff <= OVL_W'(MAX_OVL), "ring fill above depth")
   `OCS_ASSERT_IMPL(a_emit_ready, clock, reset, emit_ctl.push || emit_ctl.finish, emit_ready, "result issued while output blocked")
   `OCS_ASSERT_IMPL(a_div_idle, clock, reset, div_start, !div_busy, "divider restarted while busy")
   `OCS_ASSERT_IMPL(a_tail_commit, clock, reset, $rose(tail_valid_ff), ring_count_ff == '0, "tail taken without emptying ring")

endmodule

@@ rtl/ocs_ram.sv @@
// ----------------------------------------------------------------------------
// ocs_ram
// Simple dual-port RAM: one write port, one read port, registered read data
// that holds while no read is issued.
// ----------------------------------------------------------------------------
module ocs_ram #(
   parameter int WIDTH  = ocs_pkg::SAMPLE_W,
   parameter int DEPTH  = ocs_pkg::MAX_OVL,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ocs_div.sv @@
// ----------------------------------------------------------------------------
// ocs_div
// Restoring signed divider, one quotient bit per cycle, quotient truncated
// toward zero. Quotient holds until the next start.
// ----------------------------------------------------------------------------
module ocs_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [ocs_pkg::NUM_W-1:0]     num,
   input  logic        [ocs_pkg::OVL_W-1:0]     den,
   output logic                                 busy,
   output logic signed [ocs_pkg::SAMPLE_W-1:0]  quo
);

   localparam int NW    = ocs_pkg::NUM_W;
   localparam int DW    = ocs_pkg::OVL_W;
   localparam int CNT_W = $clog2(NW);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]    acc_ff, acc_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    den_ff, den_in;
   logic             neg_ff, neg_in;

   logic [DW:0]      trial;
   logic [ocs_pkg::SAMPLE_W-1:0] mag;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, acc_ff[NW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NW - 1);
         acc_in  = (num < 0) ? NW'(-num) : NW'(num);
         rem_in  = '0;
         den_in  = den;
         neg_in  = (num < 0);
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DW'(trial - {1'b0, den_ff});
            acc_in = {acc_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            acc_in = {acc_ff[NW-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // Magnitude is at most 2^19, which wraps to the right code when negated
   assign mag  = acc_ff[ocs_pkg::SAMPLE_W-1:0];
   assign quo  = neg_ff ? $signed(-mag) : $signed(mag);
   assign busy = busy_ff;

endmodule

@@ rtl/ocs_emit.sv @@
// ----------------------------------------------------------------------------
// ocs_emit
// Result output stage. Holds back the newest result by one so that the last
// result of a transaction can be marked when the transaction finishes.
// ----------------------------------------------------------------------------
module ocs_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  ocs_pkg::emit_ctl_type ctl,
   output logic                  ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ocs_pkg::rsp_type      rsp_data
);

   logic                                 rsp_valid_ff, rsp_valid_in;
   ocs_pkg::rsp_type                     rsp_data_ff, rsp_data_in;
   logic signed [ocs_pkg::SAMPLE_W-1:0]  hold_ff, hold_in;
   logic                                 hold_valid_ff, hold_valid_in;

   assign ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      if (ctl.push) begin
         if (hold_valid_ff) begin
            rsp_data_in.pcm      = ocs_pkg::to_pcm(hold_ff);
            rsp_data_in.run_last = 1'b0;
            rsp_valid_in         = 1'b1;
         end
         hold_in       = ctl.value;
         hold_valid_in = 1'b1;
      end else if (ctl.finish && hold_valid_ff) begin
         rsp_data_in.pcm      = ocs_pkg::to_pcm(hold_ff);
         rsp_data_in.run_last = 1'b1;
         rsp_valid_in         = 1'b1;
         hold_valid_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      hold_ff     <= hold_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Overlap crossfade stitcher testbench
// Drives sample and drain transactions into the stitcher, predicts the PCM
// stream with an independent model of the seam blending and delay line, and
// compares every result in order. A directed opening covers the field extremes
// and the seam cases. Random phases follow, each at its own overlap length
// and idling pattern, one of them with a long receiver hold-off.
// ----------------------------------------------------------------------------
localparam logic CMD_SAMPLE = 1'b0;
localparam logic CMD_DRAIN  = 1'b1;

class stitch_scoreboard;
   logic signed [ocs_pkg::SAMPLE_W-1:0] tail_mem  [ocs_pkg::MAX_OVL];
   logic signed [ocs_pkg::SAMPLE_W-1:0] delay_mem [ocs_pkg::MAX_OVL];
   bit                                  tail_held;
   int unsigned                         tail_depth;
   int unsigned                         delay_count;
   int unsigned                         delay_head;
   int unsigned                         chunk_pos;
   logic [ocs_pkg::OVL_W-1:0]           ovl_len;
   ocs_pkg::rsp_type                    pcm_due [$];
   longint                              step_out [$];
   int unsigned                         errors;

   function new();
      tail_held   = 1'b0;
      tail_depth  = 0;
      delay_count = 0;
      delay_head  = 0;
      chunk_pos   = 0;
      ovl_len     = ocs_pkg::OVL_RESET;
      errors      = 0;
   endfunction

   function void set_length(logic [ocs_pkg::OVL_W-1:0] value);
      ovl_len = value;
   endfunction

   function int unsigned span_of(logic [ocs_pkg::OVL_W-1:0] value);
      if (value == '0) return 1;
      if (value > ocs_pkg::MAX_OVL) return ocs_pkg::MAX_OVL;
      return value;
   endfunction

   function int unsigned pending();
      return pcm_due.size();
   endfunction

   function void add_step(longint value);
      step_out.insert(step_out.size(), value);
   endfunction

   function logic signed [ocs_pkg::PCM_W-1:0] pcm_of(longint value);
      longint clipped;
      clipped = value;
      if (clipped > 32768) clipped = 32768;
      if (clipped < -32768) clipped = -32768;
      return ocs_pkg::PCM_W'((clipped * 32767) / 32768);
   endfunction

   function longint pop_delay();
      longint value;
      value = delay_mem[delay_head];
      delay_head = (delay_head + 1) % ocs_pkg::MAX_OVL;
      delay_count--;
      return value;
   endfunction

   function void flush_delay();
      while (delay_count > 0) add_step(pop_delay());
      delay_head = 0;
   endfunction

   function void note_request(ocs_pkg::req_type item);
      int unsigned      span_len;
      int unsigned      pos;
      int unsigned      k;
      longint           x;
      longint           y;
      bit               blend;
      ocs_pkg::rsp_type result;
      step_out.delete();
      span_len = span_of(ovl_len);
      if (item.cmd == CMD_DRAIN) begin
         if (chunk_pos == 0 && tail_held) begin
            for (k = 0; k < span_len; k++) add_step(tail_mem[k]);
            tail_held = 1'b0;
         end
      end else begin
         x     = item.sample;
         pos   = chunk_pos;
         blend = tail_held && pos < span_len;
         if (blend || item.final_window) begin
            // empty the delay line before the sample itself goes out
            flush_delay();
            if (blend) begin
               y = (longint'(tail_mem[pos]) * longint'(span_len - pos)
                    + x * longint'(pos)) / longint'(span_len);
               add_step(y);
            end else begin
               add_step(x);
            end
         end else begin
            while (delay_count >= span_len) add_step(pop_delay());
            delay_mem[(delay_head + delay_count) % ocs_pkg::MAX_OVL] = item.sample;
            delay_count++;
         end
         if (item.chunk_end) begin
            if (!item.final_window && delay_count == span_len &&
                (tail_held || pos + 1 > span_len)) begin
               for (k = 0; k < span_len; k++)
                  tail_mem[k] = delay_mem[(delay_head + k) % ocs_pkg::MAX_OVL];
               if (span_len > tail_depth) tail_depth = span_len;
               delay_count = 0;
               delay_head  = 0;
               tail_held   = 1'b1;
            end else begin
               flush_delay();
               tail_held = 1'b0;
            end
            chunk_pos = 0;
         end else if (pos < 65535) begin
            chunk_pos = pos + 1;
         end
      end
      foreach (step_out[i]) begin
         result.pcm      = pcm_of(step_out[i]);
         result.run_last = (i == step_out.size() - 1);
         pcm_due.insert(pcm_due.size(), result);
      end
   endfunction

   function void check_result(ocs_pkg::rsp_type got);
      ocs_pkg::rsp_type want;
      if (pcm_due.size() == 0) begin
         errors++;
         $display("%0t: result with nothing expected, pcm %0d run_last %0b",
                  $time, got.pcm, got.run_last);
         return;
      end
      want = pcm_due.pop_front();
      if (got.pcm !== want.pcm) begin
         errors++;
         $display("%0t: pcm mismatch, expected %0d, got %0d", $time, want.pcm, got.pcm);
      end
      if (got.run_last !== want.run_last) begin
         errors++;
         $display("%0t: run_last mismatch, expected %0b, got %0b",
                  $time, want.run_last, got.run_last);
      end
   endfunction
endclass

module testbench;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   localparam int unsigned SETTLE_CYCLES = 200;
   localparam int unsigned CYCLE_LIMIT   = 2000000;
   localparam int unsigned HOLD_CYCLES   = 400;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   ocs_pkg::req_type          req_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   ocs_pkg::rsp_type          rsp_data;
   logic                      csr_we;
   logic [ocs_pkg::OVL_W-1:0] csr_wdata;

   stitch_scoreboard sb = new();
   int unsigned      idle_pct   = 0;
   int unsigned      stall_pct  = 0;
   int unsigned      hold_left  = 0;
   int unsigned      cycles_run = 0;

   overlap_crossfade_stitcher u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
      if (cycles_run > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // hold the receiver off for a long stretch when asked, else stall at random
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) sb.check_result(rsp_data);
   end

   function automatic logic signed [ocs_pkg::SAMPLE_W-1:0] pick_sample();
      int unsigned dice;
      dice = $urandom_range(0, 99);
      if (dice < 12) return ocs_pkg::SAMPLE_W'($urandom());
      if (dice < 22) begin
         case ($urandom_range(0, 7))
            0: return ocs_pkg::SAMPLE_W'(524287);
            1: return ocs_pkg::SAMPLE_W'(-524288);
            2: return ocs_pkg::SAMPLE_W'(32768);
            3: return ocs_pkg::SAMPLE_W'(-32768);
            4: return ocs_pkg::SAMPLE_W'(32769);
            5: return ocs_pkg::SAMPLE_W'(-32769);
            6: return ocs_pkg::SAMPLE_W'(1);
            default: return ocs_pkg::SAMPLE_W'(-1);
         endcase
      end
      return ocs_pkg::SAMPLE_W'(int'($urandom_range(0, 65536)) - 32768);
   endfunction

   task automatic send_item(ocs_pkg::req_type item);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(item);
   endtask

   task automatic send_fields(logic cmd, int value, logic chunk_end, logic final_window);
      ocs_pkg::req_type item;
      item.cmd          = cmd;
      item.sample       = ocs_pkg::SAMPLE_W'(value);
      item.chunk_end    = chunk_end;
      item.final_window = final_window;
      send_item(item);
   endtask

   // drop valid, wait for the last result, then let the block go quiet
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ovl(logic [ocs_pkg::OVL_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.set_length(value);
   endtask

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            idle_pct  = 0;
            stall_pct = 0;
         end
         IDLE_SENDER: begin
            idle_pct  = 48;
            stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            idle_pct  = 0;
            stall_pct = 48;
         end
         default: begin
            idle_pct  = 7;
            stall_pct = 7;
         end
      endcase
   endtask

   task automatic run_directed();
      settle();
      write_ovl(ocs_pkg::OVL_W'(2));
      set_idling(IDLE_NONE);
      send_fields(CMD_DRAIN, 0, 1'b0, 1'b0);          // nothing held yet
      send_fields(CMD_SAMPLE, 524287, 1'b0, 1'b0);    // short first chunk
      send_fields(CMD_SAMPLE, -524288, 1'b1, 1'b0);
      send_fields(CMD_SAMPLE, 32768, 1'b0, 1'b0);     // long chunk keeps a tail
      send_fields(CMD_SAMPLE, -32768, 1'b0, 1'b0);
      send_fields(CMD_SAMPLE, 32769, 1'b0, 1'b0);
      send_fields(CMD_SAMPLE, -1, 1'b1, 1'b0);
      send_fields(CMD_SAMPLE, 0, 1'b0, 1'b0);         // crossfade region
      send_fields(CMD_DRAIN, 0, 1'b1, 1'b1);          // chunk still open
      send_fields(CMD_SAMPLE, 1, 1'b0, 1'b0);
      send_fields(CMD_SAMPLE, 100, 1'b0, 1'b0);
      send_fields(CMD_SAMPLE, -100, 1'b0, 1'b0);
      send_fields(CMD_SAMPLE, 7, 1'b1, 1'b0);
      send_fields(CMD_DRAIN, 0, 1'b0, 1'b0);          // flush the tail
      send_fields(CMD_DRAIN, -1, 1'b0, 1'b0);
      send_fields(CMD_SAMPLE, 1000, 1'b0, 1'b0);
      send_fields(CMD_SAMPLE, 2000, 1'b0, 1'b0);
      send_fields(CMD_SAMPLE, 3000, 1'b1, 1'b0);
      send_fields(CMD_SAMPLE, 5, 1'b0, 1'b0);         // short chunk after a seam
      send_fields(CMD_SAMPLE, 6, 1'b0, 1'b0);
      send_fields(CMD_SAMPLE, 7, 1'b1, 1'b0);
      send_fields(CMD_SAMPLE, 10, 1'b0, 1'b0);
      send_fields(CMD_SAMPLE, 20, 1'b0, 1'b0);
      send_fields(CMD_SAMPLE, 30, 1'b1, 1'b0);
      send_fields(CMD_SAMPLE, -5, 1'b0, 1'b1);        // final window over a seam
      send_fields(CMD_SAMPLE, -6, 1'b1, 1'b1);
   endtask

   task automatic run_phase(logic [ocs_pkg::OVL_W-1:0] length, idle_mode_type mode,
                            bit hold_off, int unsigned budget);
      int unsigned      sent;
      int unsigned      span_len;
      int unsigned      chunk_len;
      int unsigned      i;
      int unsigned      dice;
      bit               last_window;
      bit               broken;
      ocs_pkg::req_type item;
      settle();
      span_len = sb.span_of(length);
      // close the utterance if the new length would read unwritten tail entries
      if (sb.tail_held && span_len > sb.tail_depth) begin
         send_fields(CMD_SAMPLE, 0, 1'b1, 1'b1);
         settle();
      end
      if (hold_off) hold_left = HOLD_CYCLES;
      write_ovl(length);
      set_idling(mode);
      sent = 0;
      while (sent < budget) begin
         dice = $urandom_range(0, 99);
         if (dice < 6) begin
            item.cmd          = $urandom_range(0, 1);
            item.sample       = ocs_pkg::SAMPLE_W'($urandom());
            item.chunk_end    = $urandom_range(0, 1);
            item.final_window = $urandom_range(0, 1);
            send_item(item);
            sent++;
         end else if (dice < 12) begin
            send_fields(CMD_DRAIN, int'($urandom()), $urandom_range(0, 1),
                        $urandom_range(0, 1));
            sent++;
         end else begin
            chunk_len   = $urandom_range(1, 2 * span_len + 2);
            last_window = ($urandom_range(0, 99) < 15);
            broken      = ($urandom_range(0, 99) < 5);
            for (i = 0; i < chunk_len && sent < budget; i++) begin
               item.cmd          = CMD_SAMPLE;
               item.sample       = pick_sample();
               item.chunk_end    = (i == chunk_len - 1);
               item.final_window = broken ? $urandom_range(0, 1) : last_window;
               send_item(item);
               sent++;
            end
            if (!last_window && $urandom_range(0, 99) < 25) begin
               send_fields(CMD_DRAIN, 0, 1'b0, 1'b0);
               sent++;
            end
         end
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      csr_we    = 1'b0;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      run_phase(ocs_pkg::OVL_W'(63), IDLE_NONE, 1'b0, 90);
      run_phase(ocs_pkg::OVL_W'(0), IDLE_SENDER, 1'b0, 25);
      run_phase(ocs_pkg::OVL_W'(1), IDLE_RECEIVER, 1'b0, 25);
      run_phase(ocs_pkg::OVL_W'(32), IDLE_BOTH, 1'b0, 50);
      run_phase(ocs_pkg::OVL_W'($urandom_range(2, 8)), IDLE_NONE, 1'b1, 25);
      run_phase(ocs_pkg::OVL_W'($urandom_range(3, 12)), IDLE_SENDER, 1'b0, 25);
      run_phase(ocs_pkg::OVL_W'($urandom_range(1, 20)), IDLE_RECEIVER, 1'b0, 25);
      run_phase(ocs_pkg::OVL_W'($urandom_range(0, 63)), IDLE_BOTH, 1'b0, 20);
      settle();

      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ocs_pkg.sv
rtl/ocs_ram.sv
rtl/ocs_div.sv
rtl/ocs_emit.sv
rtl/overlap_crossfade_stitcher.sv
sim/testbench.sv
